// ===== hw/rtl/teq_pkg.sv =====
// Package with the operation codes, status codes and sequencer states of the timed event queue.
`timescale 1ns / 1ps

package teq_pkg;

    // Operation codes carried in func.
    typedef enum logic [2:0] {
        FUNC_ADD       = 3'd0,
        FUNC_POP       = 3'd1,
        FUNC_FIND_HEAD = 3'd2,
        FUNC_FIND_SLOT = 3'd3,
        FUNC_REMOVE    = 3'd4
    } func_t;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam int TIME_W = 48;
    localparam int TYPE_W = 16;
    localparam int PAY_W  = 32;
    localparam int DLY_W  = 22;
    localparam int SLOT_W = 4;
    localparam logic [9:0] US_PER_MS = 10'd1000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_LINK,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/teq_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
`timescale 1ns / 1ps

module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/timed_event_queue.sv =====
// Top level of the timed event queue: a due-time ordered linked list held in RAM.
`timescale 1ns / 1ps

// Timed event queue.
// The input channel (s_axis_*) carries one operation per transfer: add, pop,
// find by type from the head or from a slot, or remove a slot. The output
// channel (m_axis_*) returns exactly one result per operation, with the
// queue's head status (empty, due, time to head) after the operation.
// Entries live in one RAM row per slot (due time, type, payload, link); the
// list is walked one entry at a time through the RAM read port (ST_WALK_RD,
// ST_WALK_CHK). After ST_MUL, an operation that walks no entry (full add,
// undefined operation, bad slot) goes straight to ST_HEAD_RD, ST_HEAD_CHK
// and ST_OUT; a pop checks at most one entry, and an add, find or remove may
// walk the whole list. After each result transfer the block returns to idle
// before it takes the next input transfer.
// One item is worked at a time: s_axis_tready is high only while idle.
// The result is held in an output register until m_axis_tready takes it;
// a stalled receiver stops the block from taking the next item.
// Reset empties the queue at once (slot-use bits cleared, head set to
// null); no clearing pass runs over the RAM.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: func[2:0], now_us[50:3], event_type[66:51],
    // payload[98:67], delay_ms[120:99], slot[124:121], zero fill.
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: status[1:0], slot_out[5:2], type_out[21:6],
    // payload_out[53:22], queue_empty[54], head_due[55],
    // time_to_head_us[103:56], zero fill.
    output logic [103:0] m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int LW = AW + 1;
    localparam int RW = teq_pkg::TIME_W + teq_pkg::TYPE_W + teq_pkg::PAY_W + LW;
    localparam logic [LW-1:0] NULL_LINK = LW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] WALK_MAX = LW'(QUEUE_DEPTH);

    // Row layout: {due, type, payload, link}.
    typedef struct packed {
        logic [teq_pkg::TIME_W-1:0] due;
        logic [teq_pkg::TYPE_W-1:0] etype;
        logic [teq_pkg::PAY_W-1:0]  pay;
        logic [LW-1:0]              link;
    } row_t;

    teq_pkg::state_t state_reg, state_next;

    // Latched operation.
    logic [2:0]                  func_reg;
    logic [teq_pkg::TIME_W-1:0]  now_reg;
    logic [teq_pkg::TYPE_W-1:0]  type_reg;
    logic [teq_pkg::PAY_W-1:0]   pay_reg;
    logic [teq_pkg::SLOT_W-1:0]  slot_reg;

    // Queue control state.
    logic [QUEUE_DEPTH-1:0] used_reg, used_next;
    logic [LW-1:0]          head_reg, head_next;

    // Walk state.
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] free_reg, free_next;
    logic [teq_pkg::TIME_W-1:0] due_reg, due_next;
    logic [teq_pkg::TIME_W:0]   prod_reg;
    row_t prev_row_reg, prev_row_next;

    // Result register.
    logic [1:0]                 st_reg, st_next;
    logic [teq_pkg::SLOT_W-1:0] so_reg, so_next;
    logic [teq_pkg::TYPE_W-1:0] to_reg, to_next;
    logic [teq_pkg::PAY_W-1:0]  po_reg, po_next;
    logic                       qe_reg, qe_next;
    logic                       hd_reg, hd_next;
    logic [teq_pkg::TIME_W-1:0] th_reg, th_next;

    // RAM port.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    row_t          wrow, rrow;

    teq_ram #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrow),
        .raddr (raddr),
        .rdata (rrow)
    );

    logic in_xfer, out_xfer;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == teq_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == teq_pkg::ST_OUT);
    assign m_axis_tdata  = {th_reg, hd_reg, qe_reg, po_reg, to_reg, so_reg, st_reg};

    // Lowest free slot.
    logic [LW-1:0] free_slot;
    always_comb
    begin
        free_slot = NULL_LINK;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = LW'(i);
            end
        end
    end

    logic [teq_pkg::TIME_W:0] due_sum;
    assign due_sum = {1'b0, now_reg} + prod_reg;

    logic slot_ok;
    assign slot_ok = (LW'(slot_reg) < NULL_LINK) && used_reg[AW'(slot_reg)];

    logic cur_valid;
    assign cur_valid = (cur_reg < NULL_LINK) && (cnt_reg < WALK_MAX);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            teq_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = teq_pkg::ST_MUL;
                end
            end
            teq_pkg::ST_MUL:
            begin
                unique case (func_reg)
                    teq_pkg::FUNC_ADD:
                        state_next = (free_slot == NULL_LINK) ? teq_pkg::ST_HEAD_RD
                                                              : teq_pkg::ST_WALK_RD;
                    teq_pkg::FUNC_POP,
                    teq_pkg::FUNC_FIND_HEAD:
                        state_next = teq_pkg::ST_WALK_RD;
                    teq_pkg::FUNC_FIND_SLOT,
                    teq_pkg::FUNC_REMOVE:
                        state_next = slot_ok ? teq_pkg::ST_WALK_RD : teq_pkg::ST_HEAD_RD;
                    default:
                        state_next = teq_pkg::ST_HEAD_RD;
                endcase
            end
            teq_pkg::ST_WALK_RD:
            begin
                state_next = cur_valid ? teq_pkg::ST_WALK_CHK : teq_pkg::ST_LINK;
            end
            teq_pkg::ST_WALK_CHK:
            begin
                state_next = teq_pkg::ST_WALK_RD;
                case (func_reg)
                    teq_pkg::FUNC_ADD:
                        if (!(due_reg > rrow.due)) state_next = teq_pkg::ST_LINK;
                    teq_pkg::FUNC_POP:
                        state_next = teq_pkg::ST_HEAD_RD;
                    teq_pkg::FUNC_FIND_HEAD,
                    teq_pkg::FUNC_FIND_SLOT:
                        if (rrow.etype == type_reg) state_next = teq_pkg::ST_HEAD_RD;
                    default:
                        if (rrow.link == LW'(slot_reg)) state_next = teq_pkg::ST_LINK;
                endcase
            end
            teq_pkg::ST_LINK:
            begin
                state_next = teq_pkg::ST_HEAD_RD;
            end
            teq_pkg::ST_HEAD_RD:
            begin
                state_next = teq_pkg::ST_HEAD_CHK;
            end
            teq_pkg::ST_HEAD_CHK:
            begin
                state_next = teq_pkg::ST_OUT;
            end
            teq_pkg::ST_OUT:
            begin
                if (out_xfer)
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = teq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        used_next     = used_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        cnt_next      = cnt_reg;
        free_next     = free_reg;
        due_next      = due_reg;
        prev_row_next = prev_row_reg;
        st_next = st_reg;
        so_next = so_reg;
        to_next = to_reg;
        po_next = po_reg;
        qe_next = qe_reg;
        hd_next = hd_reg;
        th_next = th_reg;
        we    = 1'b0;
        waddr = AW'(cur_reg);
        wrow  = rrow;
        raddr = AW'(cur_reg);
        unique case (state_reg)
            teq_pkg::ST_MUL:
            begin
                // Product is ready; set up the walk.
                st_next = teq_pkg::STATUS_MISS;
                so_next = '0;
                to_next = '0;
                po_next = '0;
                due_next = due_sum[teq_pkg::TIME_W] ? {teq_pkg::TIME_W{1'b1}}
                                                    : due_sum[teq_pkg::TIME_W-1:0];
                free_next = free_slot;
                prev_next = NULL_LINK;
                cnt_next  = '0;
                cur_next  = ((func_reg == teq_pkg::FUNC_FIND_SLOT) ||
                             (func_reg == teq_pkg::FUNC_REMOVE && LW'(slot_reg) != head_reg))
                            ? ((func_reg == teq_pkg::FUNC_FIND_SLOT) ? LW'(slot_reg) : head_reg)
                            : head_reg;
                if (func_reg == teq_pkg::FUNC_ADD && free_slot == NULL_LINK)
                begin
                    st_next = teq_pkg::STATUS_FULL;
                end
                if (func_reg == teq_pkg::FUNC_REMOVE && slot_ok)
                begin
                    st_next = teq_pkg::STATUS_OK;
                    so_next = slot_reg;
                    used_next[AW'(slot_reg)] = 1'b0;
                    if (LW'(slot_reg) == head_reg)
                    begin
                        // Head removal: the walk reads the slot and takes its link.
                        cur_next = LW'(slot_reg);
                        cnt_next = WALK_MAX - LW'(1);
                    end
                end
            end
            teq_pkg::ST_WALK_RD:
            begin
                raddr = AW'(cur_reg);
            end
            teq_pkg::ST_WALK_CHK:
            begin
                cnt_next = cnt_reg + LW'(1);
                case (func_reg)
                    teq_pkg::FUNC_ADD:
                    begin
                        if (due_reg > rrow.due)
                        begin
                            prev_next     = cur_reg;
                            prev_row_next = rrow;
                            cur_next      = rrow.link;
                        end
                    end
                    teq_pkg::FUNC_POP:
                    begin
                        st_next = teq_pkg::STATUS_OK;
                        so_next = teq_pkg::SLOT_W'(cur_reg);
                        to_next = rrow.etype;
                        po_next = rrow.pay;
                        head_next = rrow.link;
                        used_next[AW'(cur_reg)] = 1'b0;
                    end
                    teq_pkg::FUNC_FIND_HEAD,
                    teq_pkg::FUNC_FIND_SLOT:
                    begin
                        if (rrow.etype == type_reg)
                        begin
                            st_next = teq_pkg::STATUS_OK;
                            so_next = teq_pkg::SLOT_W'(cur_reg);
                            to_next = rrow.etype;
                            po_next = rrow.pay;
                        end
                        else
                        begin
                            cur_next = rrow.link;
                        end
                    end
                    default:
                    begin
                        // Remove: head case is flagged by the preset count.
                        if (cnt_reg == WALK_MAX - LW'(1))
                        begin
                            head_next = rrow.link;
                            cur_next  = NULL_LINK;
                            cnt_next  = WALK_MAX;
                        end
                        else if (rrow.link == LW'(slot_reg))
                        begin
                            prev_next     = cur_reg;
                            prev_row_next = rrow;
                        end
                        else
                        begin
                            cur_next = rrow.link;
                        end
                    end
                endcase
                // Read the removed slot's row; ST_LINK takes its link for a non-head removal.
                raddr = AW'(slot_reg);
            end
            teq_pkg::ST_LINK:
            begin
                if (func_reg == teq_pkg::FUNC_ADD)
                begin
                    // Write the new row; relink the predecessor next.
                    we    = 1'b1;
                    waddr = AW'(free_reg);
                    wrow  = '{due: due_reg, etype: type_reg, pay: pay_reg, link: cur_reg};
                    used_next[AW'(free_reg)] = 1'b1;
                    st_next = teq_pkg::STATUS_OK;
                    so_next = teq_pkg::SLOT_W'(free_reg);
                    if (prev_reg == NULL_LINK)
                    begin
                        head_next = free_reg;
                    end
                end
                else if (func_reg == teq_pkg::FUNC_REMOVE && prev_reg != NULL_LINK)
                begin
                    // rrow holds the removed slot's row.
                    we    = 1'b1;
                    waddr = AW'(prev_reg);
                    wrow  = prev_row_reg;
                    wrow.link = rrow.link;
                end
            end
            teq_pkg::ST_HEAD_RD:
            begin
                if (func_reg == teq_pkg::FUNC_ADD && prev_reg != NULL_LINK &&
                    st_reg == teq_pkg::STATUS_OK)
                begin
                    we    = 1'b1;
                    waddr = AW'(prev_reg);
                    wrow  = prev_row_reg;
                    wrow.link = free_reg;
                end
                raddr = AW'(head_reg);
            end
            teq_pkg::ST_HEAD_CHK:
            begin
                if (head_reg < NULL_LINK)
                begin
                    qe_next = 1'b0;
                    hd_next = (rrow.due <= now_reg);
                    th_next = (rrow.due > now_reg) ? (rrow.due - now_reg) : '0;
                end
                else
                begin
                    qe_next = 1'b1;
                    hd_next = 1'b0;
                    th_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= teq_pkg::ST_IDLE;
            used_reg  <= '0;
            head_reg  <= NULL_LINK;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= s_axis_tdata[2:0];
            now_reg  <= s_axis_tdata[50:3];
            type_reg <= s_axis_tdata[66:51];
            pay_reg  <= s_axis_tdata[98:67];
            slot_reg <= s_axis_tdata[124:121];
            // Delay in microseconds, ready for the add in the next cycle.
            prod_reg <= (teq_pkg::TIME_W + 1)'(32'(s_axis_tdata[120:99]) *
                                                32'(teq_pkg::US_PER_MS));
        end
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        cnt_reg      <= cnt_next;
        free_reg     <= free_next;
        due_reg      <= due_next;
        prev_row_reg <= prev_row_next;
        st_reg <= st_next;
        so_reg <= so_next;
        to_reg <= to_next;
        po_reg <= po_next;
        qe_reg <= qe_next;
        hd_reg <= hd_next;
        th_reg <= th_next;
    end

`ifndef ASSERT_OFF
    // An empty queue reports nothing due and no time left.
    a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[54] |-> !m_axis_tdata[55] && m_axis_tdata[103:56] == '0)
        else $error("empty queue reports a due head");

    // While idle, the head pointer is null exactly when no slot is in use.
    a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == teq_pkg::ST_IDLE |-> ((head_reg == NULL_LINK) == (used_reg == '0)))
        else $error("head pointer and slot-use bits disagree");

    // No new item is taken while a result waits.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while a result is pending");
`endif

endmodule

// ===== tb/timed_event_queue_tb.sv =====
// Self-checking testbench for the timed event queue with a predictor and idle phases.
`timescale 1ns / 1ps

module timed_event_queue_tb;

    localparam int DEPTH = 16;
    localparam int NULL_SLOT = DEPTH;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 20000;

    // Result fields from the highest bit down, matching m_axis_tdata.
    typedef struct packed {
        logic [47:0] time_to_head_us;
        logic        head_due;
        logic        queue_empty;
        logic [31:0] payload_out;
        logic [15:0] type_out;
        logic [3:0]  slot_out;
        logic [1:0]  status;
    } result_t;

    typedef struct {
        logic [2:0]  func;
        logic [47:0] now_us;
        logic [15:0] event_type;
        logic [31:0] payload;
        logic [21:0] delay_ms;
        logic [3:0]  slot;
        bit          has_fixed;
        result_t     fixed;
    } op_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    timed_event_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow copy of the queue.
    logic [47:0] sh_due [DEPTH];
    logic [15:0] sh_type [DEPTH];
    logic [31:0] sh_pay [DEPTH];
    int          sh_next [DEPTH];
    int          sh_head;
    bit          sh_used [DEPTH];

    result_t pending_results[$];
    op_t     ops[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_off = 0;
    int      quiet_cycles = 0;
    logic [47:0] clock_us = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int walk_for_type(int start, logic [15:0] t);
        int p;
        p = start;
        for (int n = 0; n < DEPTH && p < NULL_SLOT; n++)
        begin
            if (sh_type[p] == t) return p;
            p = sh_next[p];
        end
        return NULL_SLOT;
    endfunction

    // Applies one operation to the shadow queue and returns the expected result.
    function automatic result_t predict_queue(op_t op);
        result_t r;
        int fr, p, prev, hit;
        logic [48:0] due_wide;
        logic [47:0] due, hd;
        r = '0;
        r.status = teq_pkg::STATUS_MISS;
        case (op.func)
            teq_pkg::FUNC_ADD:
            begin
                fr = NULL_SLOT;
                for (int i = DEPTH - 1; i >= 0; i--) if (!sh_used[i]) fr = i;
                if (fr == NULL_SLOT) r.status = teq_pkg::STATUS_FULL;
                else
                begin
                    due_wide = {1'b0, op.now_us} + 49'(op.delay_ms) * 49'd1000;
                    due = due_wide[48] ? TIME_MAX : due_wide[47:0];
                    sh_due[fr] = due;
                    sh_type[fr] = op.event_type;
                    sh_pay[fr] = op.payload;
                    sh_used[fr] = 1;
                    prev = NULL_SLOT;
                    p = sh_head;
                    for (int n = 0; n < DEPTH && p < NULL_SLOT && due > sh_due[p]; n++)
                    begin
                        prev = p;
                        p = sh_next[p];
                    end
                    sh_next[fr] = p;
                    if (prev == NULL_SLOT) sh_head = fr;
                    else sh_next[prev] = fr;
                    r.status = teq_pkg::STATUS_OK;
                    r.slot_out = 4'(fr);
                end
            end
            teq_pkg::FUNC_POP:
            begin
                if (sh_head < NULL_SLOT)
                begin
                    p = sh_head;
                    r.status = teq_pkg::STATUS_OK;
                    r.slot_out = 4'(p);
                    r.type_out = sh_type[p];
                    r.payload_out = sh_pay[p];
                    sh_head = sh_next[p];
                    sh_used[p] = 0;
                end
            end
            teq_pkg::FUNC_FIND_HEAD, teq_pkg::FUNC_FIND_SLOT:
            begin
                if (op.func == teq_pkg::FUNC_FIND_HEAD)
                    hit = walk_for_type(sh_head, op.event_type);
                else if (sh_used[op.slot]) hit = walk_for_type(op.slot, op.event_type);
                else hit = NULL_SLOT;
                if (hit < NULL_SLOT)
                begin
                    r.status = teq_pkg::STATUS_OK;
                    r.slot_out = 4'(hit);
                    r.type_out = sh_type[hit];
                    r.payload_out = sh_pay[hit];
                end
            end
            teq_pkg::FUNC_REMOVE:
            begin
                if (sh_used[op.slot])
                begin
                    if (sh_head == op.slot) sh_head = sh_next[op.slot];
                    else
                    begin
                        p = sh_head;
                        for (int n = 0; n < DEPTH && p < NULL_SLOT; n++)
                        begin
                            if (sh_next[p] == op.slot)
                            begin
                                sh_next[p] = sh_next[op.slot];
                                break;
                            end
                            p = sh_next[p];
                        end
                    end
                    sh_used[op.slot] = 0;
                    r.status = teq_pkg::STATUS_OK;
                    r.slot_out = op.slot;
                end
            end
            default: ;
        endcase
        if (sh_head < NULL_SLOT)
        begin
            hd = sh_due[sh_head];
            r.queue_empty = 0;
            r.head_due = (hd <= op.now_us);
            r.time_to_head_us = (hd > op.now_us) ? hd - op.now_us : '0;
        end
        else
            r.queue_empty = 1;
        return r;
    endfunction

    function automatic op_t make_op(logic [2:0] f, logic [47:0] now, logic [15:0] t,
                                    logic [31:0] pay, logic [21:0] dly, logic [3:0] s);
        op_t o;
        o.func = f; o.now_us = now; o.event_type = t; o.payload = pay;
        o.delay_ms = dly; o.slot = s; o.has_fixed = 0; o.fixed = '0;
        return o;
    endfunction

    function automatic result_t fixed_res(logic [1:0] st, logic [3:0] s, logic e);
        result_t r;
        r = '0; r.status = st; r.slot_out = s; r.queue_empty = e;
        return r;
    endfunction

    // Random operation; mostly small times and a handful of types so finds hit.
    function automatic op_t random_op();
        op_t o;
        int k;
        k = $urandom_range(0, 99);
        clock_us = clock_us + 48'($urandom_range(0, 3000));
        o = make_op(3'(teq_pkg::FUNC_ADD), clock_us, 16'($urandom_range(0, 7)), $urandom(),
                    22'($urandom_range(0, 20)), 4'($urandom_range(0, 15)));
        if (k < 38) o.func = teq_pkg::FUNC_ADD;
        else if (k < 55) o.func = teq_pkg::FUNC_POP;
        else if (k < 68) o.func = teq_pkg::FUNC_FIND_HEAD;
        else if (k < 81) o.func = teq_pkg::FUNC_FIND_SLOT;
        else if (k < 94) o.func = teq_pkg::FUNC_REMOVE;
        else if (k < 96) o.func = 3'($urandom_range(5, 7));
        else
        begin
            // Wide values so every input bit toggles.
            o.now_us = {$urandom(), 16'($urandom())};
            o.event_type = 16'($urandom());
            o.delay_ms = 22'($urandom());
            o.func = 3'($urandom_range(0, 7));
        end
        return o;
    endfunction

    // Sender: offers items, stays valid until each transfer.
    task automatic send_op(op_t o);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {3'b0, o.slot, o.delay_ms, o.payload, o.event_type, o.now_us, o.func};
        ops.push_back(o);
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending_results.size() > 0 || ops.size() > 0) @(posedge clk);
        repeat (2 * DEPTH + 10) @(posedge clk);
    endtask

    // Predict at the input transfer so the shadow state follows the block order.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready && ops.size() > 0)
        begin
            op_t o;
            result_t r;
            o = ops.pop_front();
            r = predict_queue(o);
            if (o.has_fixed) r = o.fixed;
            pending_results.push_back(r);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_t got, want;
            got = result_t'(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected st=%0d slot=%0d type=%h pay=%h ",
                                 want.status, want.slot_out, want.type_out, want.payload_out,
                                 "e=%b d=%b t=%h, ",
                                 want.queue_empty, want.head_due, want.time_to_head_us,
                                 "got st=%0d slot=%0d type=%h pay=%h ",
                                 got.status, got.slot_out, got.type_out, got.payload_out,
                                 "e=%b d=%b t=%h",
                                 got.queue_empty, got.head_due, got.time_to_head_us);
                end
            end
        end
    end

    // Receiver stalls.
    always @(posedge clk)
    begin
        if (!rst_n) m_axis_tready <= 0;
        else m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pending_results.size() == 0 && !s_axis_tvalid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    initial
    begin
        wait (ops.size() > 0);
        repeat (300) @(posedge clk);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        op_t tbl[$];
        op_t o;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        rst_n = 0;
        sh_head = NULL_SLOT;
        for (int i = 0; i < DEPTH; i++)
        begin
            sh_used[i] = 0; sh_due[i] = 0; sh_type[i] = 0; sh_pay[i] = 0; sh_next[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed table: empty-queue misses, extremes, saturation, equal due times, full.
        o = make_op(3'(teq_pkg::FUNC_POP), 48'd0, 16'd0, 32'd0, 22'd0, 4'd0);
        o.has_fixed = 1; o.fixed = fixed_res(teq_pkg::STATUS_MISS, 4'd0, 1'b1);
        tbl.push_back(o);
        o = make_op(3'(teq_pkg::FUNC_FIND_HEAD), TIME_MAX, 16'hFFFF, 32'd0, 22'd0, 4'd0);
        o.has_fixed = 1; o.fixed = fixed_res(teq_pkg::STATUS_MISS, 4'd0, 1'b1);
        tbl.push_back(o);
        o = make_op(3'(teq_pkg::FUNC_REMOVE), 48'd0, 16'd0, 32'd0, 22'd0, 4'd15);
        o.has_fixed = 1; o.fixed = fixed_res(teq_pkg::STATUS_MISS, 4'd0, 1'b1);
        tbl.push_back(o);
        o = make_op(3'd7, 48'd5, 16'd0, 32'd0, 22'd0, 4'd0);
        o.has_fixed = 1; o.fixed = fixed_res(teq_pkg::STATUS_MISS, 4'd0, 1'b1);
        tbl.push_back(o);
        tbl.push_back(make_op(3'(teq_pkg::FUNC_ADD), TIME_MAX - 48'd5, 16'hFFFF,
                              32'hFFFF_FFFF, 22'h3F_FFFF, 4'd0));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_ADD), 48'd1000, 16'd1, 32'h1234_5678,
                              22'd2, 4'd0));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_ADD), 48'd2000, 16'd2, 32'h0BAD_F00D,
                              22'd1, 4'd0));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_ADD), 48'd0, 16'd3, 32'd0, 22'd0, 4'd0));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_FIND_HEAD), 48'd10, 16'd1, 32'd0, 22'd0, 4'd0));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_FIND_SLOT), 48'd10, 16'hFFFF, 32'd0,
                              22'd0, 4'd1));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_FIND_SLOT), 48'd10, 16'd1, 32'd0, 22'd0, 4'd9));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_REMOVE), 48'd3000, 16'd0, 32'd0, 22'd0, 4'd2));
        for (int i = 0; i < 14; i++)
            tbl.push_back(make_op(3'(teq_pkg::FUNC_ADD), 48'd4000, 16'(i), 32'(i),
                                  22'd0, 4'd0));
        tbl.push_back(make_op(3'(teq_pkg::FUNC_POP), 48'd3999, 16'd0, 32'd0, 22'd0, 4'd0));
        foreach (tbl[i]) send_op(tbl[i]);
        drain();
        // Empty the queue before random traffic.
        repeat (DEPTH)
            send_op(make_op(3'(teq_pkg::FUNC_POP), 48'd0, 16'd0, 32'd0, 22'd0, 4'd0));
        drain();

        // Random phases with different idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 71) : 0;
            recv_stall_pct = (ph == 2) ? 71 : ((ph == 3) ? 38 : 0);
            for (int n = 0; n < 460; n++) send_op(random_op());
            drain();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/teq_pkg.sv
hw/rtl/teq_ram.sv
hw/rtl/timed_event_queue.sv
tb/timed_event_queue_tb.sv
